### rtl/cursor_row_symbol_editor_core_macros.svh
// Assertion macros for the cursor row symbol editor core.
`ifndef CURSOR_ROW_SYMBOL_EDITOR_CORE_MACROS_SVH
`define CURSOR_ROW_SYMBOL_EDITOR_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CRSE_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("crse: invariant violated");

// Consequent that must hold in the cycle after the antecedent.
`define CRSE_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crse: sequence check failed");

`endif

### rtl/crse_pkg.sv
// Shared types and constants of the cursor row symbol editor.
package crse_pkg;

	localparam int OP_W       = 3;
	localparam int SYM_W      = 8;
	localparam int COL_W      = 6;
	localparam int ROW_PORT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_LEFT   = 3'd0,
		OP_RIGHT  = 3'd1,
		OP_UP     = 3'd2,
		OP_DOWN   = 3'd3,
		OP_INSERT = 3'd4,
		OP_REMOVE = 3'd5,
		OP_SET    = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN_WAIT,
		ST_READ_WAIT,
		ST_INS_SHIFT,
		ST_INS_PLACE,
		ST_REM_SHIFT,
		ST_REM_SHRINK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic sym_we;
		logic len_we;
	} store_ctl_t;

endpackage

### rtl/cursor_row_symbol_editor_core.sv
// Top level of the cursor row symbol editor: control sequencer and result register.
//
// Usage: one item on the op channel (op_valid/op_stall) is one editing operation
// on a grid of ROW_COUNT rows of up to ROW_CAPACITY byte symbols. Every item
// returns exactly one result on the res channel (res_valid/res_stall): cursor row,
// raw and clamped cursor column, current row length, and for a read the stored
// symbol and that row's length.
// Items are handled one at a time; op_stall is high while an item is in work.
// States after acceptance: left, right, set cursor: finish; up, down, read: wait,
// finish; insert: a shift per symbol from the clamped column on, place, finish;
// remove: a shift per symbol after the clamped column, shrink, finish. A blocked move,
// a read row past the grid, a full row on insert or an empty row on remove: finish only.
// Insert and remove move one symbol per cycle through the symbol memory
// (read one entry, write its neighbor in the next cycle).
// The result register loads in the last cycle of an item and shows res_valid
// from the next cycle; a held result blocks only the end of the following item.
// After reset the block sweeps both memories to zero, one entry a cycle, through the
// ROW_COUNT * ROW_CAPACITY symbol entries (1200 by default) with op_stall high.
`include "cursor_row_symbol_editor_core_macros.svh"

module cursor_row_symbol_editor_core
	import crse_pkg::*;
#(
	parameter int ROW_COUNT    = 30,
	parameter int ROW_CAPACITY = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_stall,
	input  logic [OP_W-1:0]       operation,
	input  logic [SYM_W-1:0]      symbol,
	input  logic [COL_W-1:0]      cursor_value,
	input  logic [ROW_PORT_W-1:0] read_row,
	input  logic [COL_W-1:0]      read_index,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [ROW_PORT_W-1:0] current_row,
	output logic [COL_W-1:0]      cursor_raw,
	output logic [COL_W-1:0]      cursor_effective,
	output logic [COL_W-1:0]      current_length,
	output logic [SYM_W-1:0]      read_symbol,
	output logic [COL_W-1:0]      read_length
);

	localparam int SYM_DEPTH = ROW_COUNT * ROW_CAPACITY;
	localparam int SA_W      = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
	localparam int CLR_W     = $clog2(SYM_DEPTH + 1);
	localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	localparam logic [SA_W-1:0]  CAP_A     = SA_W'(ROW_CAPACITY);
	localparam logic [COL_W-1:0] CAP_C     = COL_W'(ROW_CAPACITY);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROW_COUNT - 1);
	localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(SYM_DEPTH - 1);
	localparam logic [CLR_W-1:0] CLR_ROWS  = CLR_W'(ROW_COUNT);
	localparam logic [8:0]       RROW_LIM  = 9'(ROW_COUNT);

	function automatic logic [COL_W-1:0] eff_col(input logic [COL_W-1:0] col,
	                                             input logic [COL_W-1:0] len);
		return (col > len) ? len : col;
	endfunction

	function automatic logic [COL_W-1:0] step_right(input logic [COL_W-1:0] col,
	                                                input logic [COL_W-1:0] len);
		logic [COL_W-1:0] e;
		e = eff_col(col, len);
		return (e < len) ? e + 1'b1 : e;
	endfunction

	state_t           state_q, state_d;
	logic [CLR_W-1:0] clr_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] len_q;
	logic             res_valid_q;

	logic [SYM_W-1:0] sym_q;
	logic [SA_W-1:0]  base_q;
	logic [COL_W-1:0] cnt_q;
	logic             ridx_ok_q;
	logic [SYM_W-1:0] rsym_q;
	logic [COL_W-1:0] rlen_q;

	logic [ROW_PORT_W-1:0] current_row_q;
	logic [COL_W-1:0]      cursor_raw_q;
	logic [COL_W-1:0]      cursor_effective_q;
	logic [COL_W-1:0]      current_length_q;
	logic [SYM_W-1:0]      read_symbol_q;
	logic [COL_W-1:0]      read_length_q;

	store_ctl_t       ctl;
	logic [SA_W-1:0]  sym_wr_addr, sym_rd_addr;
	logic [SYM_W-1:0] sym_wr_data, sym_rd_data;
	logic [ROW_W-1:0] len_wr_addr, len_rd_addr;
	logic [COL_W-1:0] len_wr_data, len_rd_data;

	op_t              op_c;
	logic [COL_W-1:0] eff_c;
	logic [SA_W-1:0]  row_base_c;
	logic [SA_W-1:0]  rd_base_c;
	logic             rrow_ok_c;
	logic             ridx_ok_c;
	logic             down_ok_c;
	logic             out_free_c;
	logic [COL_W-1:0] len_inc_c;
	logic [COL_W-1:0] len_dec_c;

	assign op_c       = op_t'(operation);
	assign eff_c      = eff_col(col_q, len_q);
	assign row_base_c = SA_W'(row_q) * CAP_A;
	assign rd_base_c  = SA_W'(ROW_W'(read_row)) * CAP_A;
	assign rrow_ok_c  = {4'd0, read_row} < RROW_LIM;
	assign ridx_ok_c  = read_index < CAP_C;
	assign down_ok_c  = (len_q != '0) && (row_q != ROW_LAST);
	assign out_free_c = !res_valid_q || !res_stall;
	assign len_inc_c  = len_q + 1'b1;
	assign len_dec_c  = len_q - 1'b1;
	assign op_stall   = (state_q != ST_IDLE);

	crse_store #(
		.SYM_DEPTH (SYM_DEPTH),
		.SA_W      (SA_W),
		.ROW_COUNT (ROW_COUNT),
		.ROW_W     (ROW_W)
	) u_store (
		.clk         (clk),
		.ctl         (ctl),
		.sym_wr_addr (sym_wr_addr),
		.sym_wr_data (sym_wr_data),
		.sym_rd_addr (sym_rd_addr),
		.sym_rd_data (sym_rd_data),
		.len_wr_addr (len_wr_addr),
		.len_wr_data (len_wr_data),
		.len_rd_addr (len_rd_addr),
		.len_rd_data (len_rd_data)
	);

	// Sequencer: next state and memory port control.
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		sym_wr_addr = '0;
		sym_wr_data = '0;
		sym_rd_addr = '0;
		len_wr_addr = '0;
		len_wr_data = '0;
		len_rd_addr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.sym_we  = 1'b1;
				sym_wr_addr = clr_q[SA_W-1:0];
				if (clr_q < CLR_ROWS) begin
					ctl.len_we  = 1'b1;
					len_wr_addr = clr_q[ROW_W-1:0];
				end
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (op_valid) begin
					state_d = ST_FINISH;
					unique case (op_c) inside
						OP_LEFT, OP_RIGHT, OP_SET: begin
							state_d = ST_FINISH;
						end
						OP_UP: begin
							if (row_q != '0) begin
								len_rd_addr = row_q - 1'b1;
								state_d     = ST_LEN_WAIT;
							end
						end
						OP_DOWN: begin
							if (down_ok_c) begin
								len_rd_addr = row_q + 1'b1;
								state_d     = ST_LEN_WAIT;
							end
						end
						OP_INSERT: begin
							if (len_q < CAP_C) begin
								if (len_q > eff_c) begin
									sym_rd_addr = row_base_c + SA_W'(len_q - 1'b1);
									state_d     = ST_INS_SHIFT;
								end else begin
									state_d = ST_INS_PLACE;
								end
							end
						end
						OP_REMOVE: begin
							if (len_q != '0) begin
								if (({1'b0, eff_c} + 7'd1) < {1'b0, len_q}) begin
									sym_rd_addr = row_base_c + SA_W'(eff_c + 1'b1);
									state_d     = ST_REM_SHIFT;
								end else begin
									state_d = ST_REM_SHRINK;
								end
							end
						end
						OP_READ: begin
							if (rrow_ok_c) begin
								len_rd_addr = ROW_W'(read_row);
								if (ridx_ok_c) begin
									sym_rd_addr = rd_base_c + SA_W'(read_index);
								end
								state_d = ST_READ_WAIT;
							end
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_LEN_WAIT, ST_READ_WAIT: begin
				state_d = ST_FINISH;
			end
			ST_INS_SHIFT: begin
				// symbol read last cycle moves one place right
				ctl.sym_we  = 1'b1;
				sym_wr_addr = base_q + SA_W'(cnt_q + 1'b1);
				sym_wr_data = sym_rd_data;
				if (cnt_q > eff_c) begin
					sym_rd_addr = base_q + SA_W'(cnt_q - 1'b1);
				end else begin
					state_d = ST_INS_PLACE;
				end
			end
			ST_INS_PLACE: begin
				ctl.sym_we  = 1'b1;
				sym_wr_addr = base_q + SA_W'(eff_c);
				sym_wr_data = sym_q;
				ctl.len_we  = 1'b1;
				len_wr_addr = row_q;
				len_wr_data = len_inc_c;
				state_d     = ST_FINISH;
			end
			ST_REM_SHIFT: begin
				// symbol read last cycle moves one place left
				ctl.sym_we  = 1'b1;
				sym_wr_addr = base_q + SA_W'(cnt_q - 1'b1);
				sym_wr_data = sym_rd_data;
				if (({1'b0, cnt_q} + 7'd1) < {1'b0, len_q}) begin
					sym_rd_addr = base_q + SA_W'(cnt_q + 1'b1);
				end else begin
					state_d = ST_REM_SHRINK;
				end
			end
			ST_REM_SHRINK: begin
				ctl.len_we  = 1'b1;
				len_wr_addr = row_q;
				len_wr_data = len_dec_c;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free_c) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Cursor, cached current row length and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						case (op_c)
							OP_LEFT: begin
								if (col_q != '0) begin
									col_q <= col_q - 1'b1;
								end
							end
							OP_RIGHT: col_q <= step_right(col_q, len_q);
							OP_UP: begin
								if (row_q != '0) begin
									row_q <= row_q - 1'b1;
								end
							end
							OP_DOWN: begin
								if (down_ok_c) begin
									row_q <= row_q + 1'b1;
								end
							end
							OP_INSERT: begin
								// full row: cursor still steps right
								if (len_q >= CAP_C) begin
									col_q <= step_right(col_q, len_q);
								end
							end
							OP_SET:  col_q <= cursor_value;
							default: ;
						endcase
					end
				end
				ST_LEN_WAIT: len_q <= len_rd_data;
				ST_INS_PLACE: begin
					len_q <= len_inc_c;
					col_q <= step_right(col_q, len_inc_c);
				end
				ST_REM_SHRINK: len_q <= len_dec_c;
				default: ;
			endcase
			if (state_q == ST_FINISH && out_free_c) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Item payload, shift counter and result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && op_valid) begin
			sym_q     <= symbol;
			base_q    <= row_base_c;
			ridx_ok_q <= ridx_ok_c;
			rsym_q    <= '0;
			rlen_q    <= '0;
			cnt_q     <= (op_c == OP_INSERT) ? len_q - 1'b1 : eff_c + 1'b1;
		end
		if (state_q == ST_INS_SHIFT && cnt_q > eff_c) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == ST_REM_SHIFT) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_READ_WAIT) begin
			rlen_q <= len_rd_data;
			rsym_q <= ridx_ok_q ? sym_rd_data : '0;
		end
		if (state_q == ST_FINISH && out_free_c) begin
			current_row_q      <= ROW_PORT_W'(row_q);
			cursor_raw_q       <= col_q;
			cursor_effective_q <= eff_c;
			current_length_q   <= len_q;
			read_symbol_q      <= rsym_q;
			read_length_q      <= rlen_q;
		end
	end

	assign res_valid        = res_valid_q;
	assign current_row      = current_row_q;
	assign cursor_raw       = cursor_raw_q;
	assign cursor_effective = cursor_effective_q;
	assign current_length   = current_length_q;
	assign read_symbol      = read_symbol_q;
	assign read_length      = read_length_q;

	`CRSE_CHECK(a_len_cap, len_q <= CAP_C)
	`CRSE_CHECK(a_row_range, row_q <= ROW_LAST)
	`CRSE_CHECK(a_ins_room, (state_q != ST_INS_PLACE) || (len_q < CAP_C))
	`CRSE_CHECK_NEXT(a_result_load, state_q == ST_FINISH && out_free_c, res_valid_q && state_q == ST_IDLE)

endmodule

### rtl/crse_store.sv
// Symbol memory and row length memory, one write and one registered read port each.
module crse_store
	import crse_pkg::*;
#(
	parameter int SYM_DEPTH = 1200,
	parameter int SA_W      = 11,
	parameter int ROW_COUNT = 30,
	parameter int ROW_W     = 5
) (
	input  logic              clk,
	input  store_ctl_t        ctl,
	input  logic [SA_W-1:0]   sym_wr_addr,
	input  logic [SYM_W-1:0]  sym_wr_data,
	input  logic [SA_W-1:0]   sym_rd_addr,
	output logic [SYM_W-1:0]  sym_rd_data,
	input  logic [ROW_W-1:0]  len_wr_addr,
	input  logic [COL_W-1:0]  len_wr_data,
	input  logic [ROW_W-1:0]  len_rd_addr,
	output logic [COL_W-1:0]  len_rd_data
);

	logic [SYM_W-1:0] sym_mem [SYM_DEPTH];
	logic [COL_W-1:0] len_mem [ROW_COUNT];

	always_ff @(posedge clk) begin
		if (ctl.sym_we) begin
			sym_mem[sym_wr_addr] <= sym_wr_data;
		end
		sym_rd_data <= sym_mem[sym_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.len_we) begin
			len_mem[len_wr_addr] <= len_wr_data;
		end
		len_rd_data <= len_mem[len_rd_addr];
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the cursor row symbol editor core: directed and random edits against a grid model.
module tb_top
	import crse_pkg::*;
();

	localparam int ROWS         = 30;
	localparam int CAP          = 40;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 60;

	// One result as the editor reports it.
	typedef struct packed {
		logic [ROW_PORT_W-1:0] row;
		logic [COL_W-1:0]      raw;
		logic [COL_W-1:0]      eff;
		logic [COL_W-1:0]      len;
		logic [SYM_W-1:0]      rsym;
		logic [COL_W-1:0]      rlen;
	} editor_view_t;

	logic                  clk;
	logic                  arst_n;
	logic                  op_valid;
	logic                  op_stall;
	logic [OP_W-1:0]       operation;
	logic [SYM_W-1:0]      symbol;
	logic [COL_W-1:0]      cursor_value;
	logic [ROW_PORT_W-1:0] read_row;
	logic [COL_W-1:0]      read_index;
	logic                  res_valid;
	logic                  res_stall;
	logic [ROW_PORT_W-1:0] current_row;
	logic [COL_W-1:0]      cursor_raw;
	logic [COL_W-1:0]      cursor_effective;
	logic [COL_W-1:0]      current_length;
	logic [SYM_W-1:0]      read_symbol;
	logic [COL_W-1:0]      read_length;

	// Grid model
	logic [SYM_W-1:0] grid [ROWS][CAP];
	int               row_len [ROWS];
	int               cur_row;
	int               cur_col;

	editor_view_t queued_views [$];
	int           fail_count;
	int           quiet_cycles;
	bit           no_idle;

	cursor_row_symbol_editor_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int clamped_col();
		return (cur_col > row_len[cur_row]) ? row_len[cur_row] : cur_col;
	endfunction

	function automatic void cursor_right();
		cur_col = clamped_col();
		if (cur_col < row_len[cur_row])
			cur_col++;
	endfunction

	function automatic editor_view_t apply_edit(op_t op, logic [SYM_W-1:0] sym,
			logic [COL_W-1:0] cval, logic [ROW_PORT_W-1:0] rrow, logic [COL_W-1:0] ridx);
		editor_view_t v;
		int pos;
		int len;
		int n;
		v = '0;
		pos = clamped_col();
		len = row_len[cur_row];
		case (op)
			OP_LEFT: if (cur_col > 0) cur_col--;
			OP_RIGHT: cursor_right();
			OP_UP: if (cur_row > 0) cur_row--;
			OP_DOWN: if (len != 0 && cur_row < ROWS - 1) cur_row++;
			OP_INSERT: begin
				// a full row keeps its contents, the cursor still steps right
				if (len < CAP) begin
					for (n = len; n > pos; n--)
						grid[cur_row][n] = grid[cur_row][n - 1];
					grid[cur_row][pos] = sym;
					row_len[cur_row] = len + 1;
				end
				cursor_right();
			end
			OP_REMOVE: begin
				// at the end of the row the last symbol goes; stale bytes stay
				if (len != 0) begin
					for (n = pos + 1; n < len; n++)
						grid[cur_row][n - 1] = grid[cur_row][n];
					row_len[cur_row] = len - 1;
				end
			end
			OP_SET: cur_col = int'(cval);
			OP_READ: if (rrow < ROWS) begin
				v.rlen = COL_W'(row_len[rrow]);
				if (ridx < CAP)
					v.rsym = grid[rrow][ridx];
			end
			default: ;
		endcase
		v.row = ROW_PORT_W'(cur_row);
		v.raw = COL_W'(cur_col);
		v.eff = COL_W'(clamped_col());
		v.len = COL_W'(row_len[cur_row]);
		return v;
	endfunction

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic send_edit(op_t op, logic [SYM_W-1:0] sym, logic [COL_W-1:0] cval,
			logic [ROW_PORT_W-1:0] rrow, logic [COL_W-1:0] ridx);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation    <= op;
		symbol       <= sym;
		cursor_value <= cval;
		read_row     <= rrow;
		read_index   <= ridx;
		op_valid     <= 1'b1;
		do @(posedge clk); while (op_stall);
		queued_views.push_back(apply_edit(op, sym, cval, rrow, ridx));
	endtask

	// Random content in every field, unused ones included.
	task automatic send_any(op_t op);
		logic [COL_W-1:0]      cval;
		logic [ROW_PORT_W-1:0] rrow;
		logic [COL_W-1:0]      ridx;
		cval = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, CAP + 2))
			: COL_W'($urandom_range(0, 63));
		rrow = ($urandom_range(0, 99) < 88) ? ROW_PORT_W'($urandom_range(0, ROWS - 1))
			: ROW_PORT_W'($urandom_range(ROWS, 31));
		ridx = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, CAP - 1))
			: COL_W'($urandom_range(CAP, 63));
		send_edit(op, SYM_W'($urandom_range(0, 255)), cval, rrow, ridx);
	endtask

	task automatic test_reset_state();
		send_edit(OP_READ, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_READ, 8'hFF, 6'd63, 5'd29, 6'd39);
		send_edit(OP_READ, 8'h00, 6'd0, 5'd30, 6'd0);   // row past the grid
		send_edit(OP_READ, 8'h00, 6'd0, 5'd31, 6'd63);
		send_edit(OP_READ, 8'h00, 6'd0, 5'd7, 6'd40);   // index past capacity
	endtask

	task automatic test_cursor_moves();
		send_edit(OP_LEFT, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_RIGHT, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_DOWN, 8'h00, 6'd0, 5'd0, 6'd0);    // blocked, row is empty
		send_edit(OP_UP, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_SET, 8'h00, 6'd63, 5'd0, 6'd0);
		send_edit(OP_LEFT, 8'h00, 6'd0, 5'd0, 6'd0);    // raw column, no clamp
		send_edit(OP_SET, 8'h00, 6'd63, 5'd0, 6'd0);
		send_edit(OP_RIGHT, 8'h00, 6'd0, 5'd0, 6'd0);   // clamps first
	endtask

	task automatic test_row_edits();
		send_edit(OP_SET, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_INSERT, 8'hFF, 6'd0, 5'd0, 6'd0);
		send_edit(OP_INSERT, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_SET, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_INSERT, 8'hA5, 6'd0, 5'd0, 6'd0);  // shifts the row right
		send_edit(OP_REMOVE, 8'h00, 6'd0, 5'd0, 6'd0);  // removes mid-row
		send_edit(OP_SET, 8'h00, 6'd63, 5'd0, 6'd0);
		send_edit(OP_REMOVE, 8'h00, 6'd0, 5'd0, 6'd0);  // cursor at end: last symbol
		send_edit(OP_READ, 8'h00, 6'd0, 5'd0, 6'd2);    // stale byte past the end
		send_edit(OP_DOWN, 8'h00, 6'd0, 5'd0, 6'd0);
		send_edit(OP_REMOVE, 8'h00, 6'd0, 5'd0, 6'd0);  // empty row
		send_edit(OP_INSERT, 8'h5A, 6'd0, 5'd0, 6'd0);
		send_edit(OP_UP, 8'h00, 6'd0, 5'd0, 6'd0);
	endtask

	task automatic test_walk_rows();
		while (cur_row < ROWS - 1) begin
			if ($urandom_range(0, 3) != 0)
				send_any(OP_INSERT);
			send_any(OP_DOWN);
		end
		repeat (2) send_any(OP_DOWN);
		send_any(OP_INSERT);
		send_any(OP_DOWN);                              // bottom row: stays
		while (cur_row > 0)
			send_any(OP_UP);
		send_any(OP_UP);
	endtask

	task automatic test_full_row();
		repeat (2) begin
			repeat ($urandom_range(0, 5)) send_any(OP_DOWN);
			repeat (CAP + 4) begin
				if ($urandom_range(0, 3) == 0)
					send_any(OP_SET);
				else
					send_any(OP_INSERT);
			end
			repeat (12)
				send_edit(OP_READ, SYM_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
					ROW_PORT_W'(cur_row), COL_W'($urandom_range(0, CAP - 1)));
			repeat (CAP + 3) begin
				if ($urandom_range(0, 3) == 0)
					send_any(OP_SET);
				else
					send_any(OP_REMOVE);
			end
		end
	endtask

	task automatic test_random_edits(int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				send_any(OP_LEFT);
			else if (r < 24)
				send_any(OP_RIGHT);
			else if (r < 30)
				send_any(OP_UP);
			else if (r < 36)
				send_any(OP_DOWN);
			else if (r < 64)
				send_any(OP_INSERT);
			else if (r < 78)
				send_any(OP_REMOVE);
			else if (r < 84)
				send_any(OP_SET);
			else
				send_any(OP_READ);
		end
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random_edits(150);
		no_idle = 1'b0;
	endtask

	task automatic check_field(string name, logic [SYM_W-1:0] want, logic [SYM_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Result checker
	initial begin
		editor_view_t want;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				if (queued_views.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					want = queued_views.pop_front();
					check_field("current_row", SYM_W'(want.row), SYM_W'(current_row));
					check_field("cursor_raw", SYM_W'(want.raw), SYM_W'(cursor_raw));
					check_field("cursor_effective", SYM_W'(want.eff),
						SYM_W'(cursor_effective));
					check_field("current_length", SYM_W'(want.len), SYM_W'(current_length));
					check_field("read_symbol", want.rsym, read_symbol);
					check_field("read_length", SYM_W'(want.rlen), SYM_W'(read_length));
				end
			end
		end
	end

	// Result-side stall
	initial begin
		int hold;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			res_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	// Watchdog: covers the clearing sweep after reset plus the longest stalls
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((op_valid && !op_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAIL cursor_row_symbol_editor_core");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int c;
		arst_n       = 1'b0;
		op_valid     = 1'b0;
		operation    = OP_LEFT;
		symbol       = '0;
		cursor_value = '0;
		read_row     = '0;
		read_index   = '0;
		fail_count   = 0;
		no_idle      = 1'b0;
		cur_row      = 0;
		cur_col      = 0;
		for (r = 0; r < ROWS; r++) begin
			row_len[r] = 0;
			for (c = 0; c < CAP; c++)
				grid[r][c] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_cursor_moves();
		test_row_edits();
		test_walk_rows();
		test_full_row();
		test_random_edits(1200);
		test_back_to_back();

		@(negedge clk);
		op_valid <= 1'b0;
		while (queued_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS cursor_row_symbol_editor_core");
		else
			$display("FAIL cursor_row_symbol_editor_core");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/crse_pkg.sv
rtl/crse_store.sv
rtl/cursor_row_symbol_editor_core.sv
tb/tb_top.sv
